FILE: hw/rtl/sha1s_pkg.sv
package sha1s_pkg;

    // one input item as it arrives on the port
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       message_end;
    } in_item_t;

    // one digest word as it leaves the block
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // classified command passed from front to back through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } cmd_t;

    localparam logic [31:0] SHA1S_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1S_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1S_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1S_K3 = 32'hCA62C1D6;

    localparam logic [0:4][31:0] SHA1S_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] SHA1S_PAD_BYTE   = 8'h80;
    localparam logic [5:0] SHA1S_LEN_POS    = 6'd56;
    localparam logic [5:0] SHA1S_LAST_POS   = 6'd63;
    localparam logic [6:0] SHA1S_LAST_ROUND = 7'd79;
    localparam logic [2:0] SHA1S_LAST_WORD  = 3'd4;
    localparam logic [2:0] SHA1S_LAST_LEN   = 3'd7;

    function automatic logic [31:0] sha1s_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        if (rnd < 7'd20) begin
            res = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            res = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            res = (b & c) | (b & d) | (c & d);
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic logic [31:0] sha1s_k(input logic [6:0] rnd);
        logic [31:0] res;
        if (rnd < 7'd20) begin
            res = SHA1S_K0;
        end else if (rnd < 7'd40) begin
            res = SHA1S_K1;
        end else if (rnd < 7'd60) begin
            res = SHA1S_K2;
        end else begin
            res = SHA1S_K3;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/sha1s_front.sv
module sha1s_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  sha1s_pkg::in_item_t item,
    input  logic                q_full,
    output logic                cmd_valid,
    output sha1s_pkg::cmd_t     cmd
);

    logic            hold_valid_reg;
    sha1s_pkg::cmd_t hold_reg;
    logic            accept;
    logic            useful;

    assign item_stall = hold_valid_reg && q_full;
    assign accept     = item_valid && !item_stall;
    // an item with neither byte nor end changes nothing and is dropped here
    assign useful     = item.byte_present || item.message_end;
    assign cmd_valid  = hold_valid_reg && !q_full;
    assign cmd        = hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept && useful)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (cmd_valid)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && useful)
        begin
            hold_reg.data     <= item.msg_byte;
            hold_reg.has_byte <= item.byte_present;
            hold_reg.is_end   <= item.message_end;
        end
    end

endmodule

FILE: hw/rtl/sha1s_queue.sv
module sha1s_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sha1s_pkg::cmd_t wdata,
    output logic            full,
    input  logic            pop,
    output logic            rvalid,
    output sha1s_pkg::cmd_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1s_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !rvalid))
        else $error("queue underflow");

endmodule

FILE: hw/rtl/sha1s_core.sv
module sha1s_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  sha1s_pkg::cmd_t      cmd,
    output logic                 cmd_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sha1s_pkg::out_item_t result
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PAD_MARK = 7'b0000010,
        ST_PAD_ZERO = 7'b0000100,
        ST_PAD_LEN  = 7'b0001000,
        ST_ROUND    = 7'b0010000,
        ST_ADD      = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } state_t;

    // what follows a compression
    typedef enum logic [2:0] {
        PH_DATA  = 3'b001,
        PH_ZERO  = 3'b010,
        PH_FINAL = 3'b100
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [5:0]  fill_reg;
    logic [63:0] count_reg;
    logic [63:0] len_reg;
    logic [2:0]  len_cnt_reg;
    logic [6:0]  round_reg;
    logic        pend_end_reg;
    logic [2:0]  emit_idx_reg;
    logic [31:0] chain_reg [5];
    logic [511:0] buf_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic        out_valid_reg;
    sha1s_pkg::out_item_t out_reg;

    logic        ins;
    logic [7:0]  ins_byte;
    logic        out_free;
    logic        out_load;
    logic        go_round;
    logic [31:0] w0, w_mix, w_new, t_sum;

    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cmd_pop      = (state_reg == ST_IDLE) && cmd_valid;

    // message schedule window: word i sits at buf_reg[511-32*i -: 32]
    assign w0    = buf_reg[511:480];
    assign w_mix = buf_reg[95:64] ^ buf_reg[255:224] ^ buf_reg[447:416] ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign t_sum = {a_reg[26:0], a_reg[31:27]}
                 + sha1s_pkg::sha1s_f(round_reg, b_reg, c_reg, d_reg)
                 + e_reg + sha1s_pkg::sha1s_k(round_reg) + w0;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ins        = 1'b0;
        ins_byte   = 8'h00;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.has_byte)
                    begin
                        ins      = 1'b1;
                        ins_byte = cmd.data;
                        if (fill_reg == sha1s_pkg::SHA1S_LAST_POS)
                        begin
                            state_next = ST_ROUND;
                            phase_next = PH_DATA;
                        end
                        else if (cmd.is_end)
                        begin
                            state_next = ST_PAD_MARK;
                        end
                    end
                    else
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                ins      = 1'b1;
                ins_byte = sha1s_pkg::SHA1S_PAD_BYTE;
                if (fill_reg == sha1s_pkg::SHA1S_LAST_POS)
                begin
                    state_next = ST_ROUND;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == sha1s_pkg::SHA1S_LEN_POS)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    ins = 1'b1;
                    if (fill_reg == sha1s_pkg::SHA1S_LAST_POS)
                    begin
                        state_next = ST_ROUND;
                        phase_next = PH_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                ins      = 1'b1;
                ins_byte = len_reg[63:56];
                if (len_cnt_reg == sha1s_pkg::SHA1S_LAST_LEN)
                begin
                    state_next = ST_ROUND;
                    phase_next = PH_FINAL;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == sha1s_pkg::SHA1S_LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                case (phase_reg)
                    PH_FINAL: state_next = ST_EMIT;
                    PH_ZERO:  state_next = ST_PAD_ZERO;
                    default:  state_next = pend_end_reg ? ST_PAD_MARK : ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (emit_idx_reg == sha1s_pkg::SHA1S_LAST_WORD)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign go_round = (state_next == ST_ROUND) && (state_reg != ST_ROUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DATA;
            fill_reg      <= '0;
            count_reg     <= '0;
            len_cnt_reg   <= '0;
            round_reg     <= '0;
            pend_end_reg  <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= sha1s_pkg::SHA1S_IV[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (ins)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd_pop && cmd.has_byte)
            begin
                count_reg <= count_reg + 64'd1;
            end
            if (cmd_pop)
            begin
                pend_end_reg <= cmd.is_end;
            end
            else if (state_reg == ST_PAD_MARK)
            begin
                pend_end_reg <= 1'b0;
                count_reg    <= '0;
                len_cnt_reg  <= '0;
            end
            if (state_reg == ST_PAD_LEN)
            begin
                len_cnt_reg <= len_cnt_reg + 3'd1;
            end
            if (go_round)
            begin
                round_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 7'd1;
            end
            if (state_reg == ST_ADD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
                emit_idx_reg <= '0;
            end
            if (out_load)
            begin
                emit_idx_reg <= emit_idx_reg + 3'd1;
                if (emit_idx_reg == sha1s_pkg::SHA1S_LAST_WORD)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_reg[i] <= sha1s_pkg::SHA1S_IV[i];
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            buf_reg <= {buf_reg[503:0], ins_byte};
        end
        else if (state_reg == ST_ROUND)
        begin
            buf_reg <= {buf_reg[479:0], w_new};
        end
        if (state_reg == ST_PAD_MARK)
        begin
            len_reg <= {count_reg[60:0], 3'b000};
        end
        else if (state_reg == ST_PAD_LEN)
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
        if (go_round)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (state_reg == ST_ROUND)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end
        if (out_load)
        begin
            out_reg.digest_word <= chain_reg[emit_idx_reg];
            out_reg.word_index  <= emit_idx_reg;
            out_reg.last_word   <= (emit_idx_reg == sha1s_pkg::SHA1S_LAST_WORD);
        end
    end

    // a closing compression always starts from a full block, so the buffer is empty after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && phase_reg == PH_FINAL) |-> (fill_reg == 6'd0))
        else $error("final block not aligned");
    // the round counter never passes the last round of a compression
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= sha1s_pkg::SHA1S_LAST_ROUND))
        else $error("round counter out of range");
    // the last mark goes on the fifth digest word and on no other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_reg.last_word == (out_reg.word_index == sha1s_pkg::SHA1S_LAST_WORD)))
        else $error("last word mark mismatch");

endmodule

FILE: hw/rtl/sha1_stream_hasher.sv
// channel   direction  handshake                    payload
// item      in         item_valid / item_stall      msg_byte, byte_present, message_end
// result    out        result_valid / result_stall  digest_word, word_index, last_word
//
// the back end takes a new byte from the queue whenever it is idle; every 64th byte starts a
// compression on the shared round unit, its rounds and then an add step
// a message end adds padding bytes (up to 72) and one or two compressions, then the back end
// hands out the five digest words
// reset is asynchronous, active low; no clearing pass, the block is ready right after reset
// the front register and a small queue keep taking items while the back end compresses
// result stall holds the output register; the back end waits only when it must load a word
module sha1_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  sha1s_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sha1s_pkg::out_item_t result
);

    // classified items between the front register and the queue
    logic            front_valid;
    sha1s_pkg::cmd_t front_cmd;
    logic            q_full;

    // queue to back end
    logic            q_valid;
    logic            q_pop;
    sha1s_pkg::cmd_t q_cmd;

    // front: registers each item and drops those that carry neither byte nor end
    sha1s_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .cmd_valid  (front_valid),
        .cmd        (front_cmd)
    );

    // short queue that holds items from the front while the round unit is busy
    sha1s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_valid),
        .wdata  (front_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_cmd)
    );

    // back end: block buffer, padding sequencer, round unit and output register
    sha1s_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
